### sv/mbfr_pkg.sv
`timescale 1ns / 1ps

package mbfr_pkg;

	// fixed field widths
	localparam int FIELD_W        = 32;
	localparam int NBITS_W        = 6;
	localparam int MAX_FIELD_BITS = 32;

	// widest positions the op record can carry (largest supported store)
	localparam int MAX_ADDR_W = 12;
	localparam int MAX_POS_W  = 15;

	// request codes
	localparam logic [1:0] REQ_PUSH  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// work handed from front to back
	typedef enum logic [1:0] {
		OP_NONE,
		OP_WRITE,
		OP_EXTRACT
	} op_kind_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] data_byte;
		logic [5:0] bit_count;
	} in_item_t;

	typedef struct packed {
		logic [31:0] field_value;
		logic [1:0]  status;
	} out_item_t;

	typedef struct packed {
		op_kind_t              kind;
		logic [1:0]            status;
		logic [7:0]            data;
		logic [MAX_ADDR_W-1:0] addr;
		logic [MAX_POS_W-1:0]  pos;
		logic [NBITS_W-1:0]    nbits;
	} op_t;

endpackage

### sv/mbfr_fifo.sv
`timescale 1ns / 1ps

module mbfr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wr_ptr_q;
	logic [AW:0]      rd_ptr_q;
	logic             do_push;
	logic             do_pop;

	// occupancy flags from wrapped pointers
	assign empty   = (wr_ptr_q == rd_ptr_q);
	assign full    = (wr_ptr_q[AW] != rd_ptr_q[AW]) &&
	                 (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q[AW-1:0]];

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q[AW-1:0]] <= wdata;
		end
	end

endmodule

### sv/mbfr_front.sv
`timescale 1ns / 1ps

module mbfr_front #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mbfr_pkg::in_item_t item,
	output logic              full,
	input  logic              q_full,
	output logic              q_push,
	output mbfr_pkg::op_t     q_op
);

	import mbfr_pkg::*;

	localparam int TB = BUFFER_BYTES * 8;
	localparam int PW = $clog2(TB);
	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int CW = $clog2(TB + 1);

	logic [PW-1:0]      rd_pos_q, rd_pos_d;
	logic [AW-1:0]      wr_pos_q, wr_pos_d;
	logic [CW-1:0]      count_q, count_d;
	logic               accept;
	logic [NBITS_W-1:0] nbits;
	logic [CW:0]        count_plus8;
	logic [PW:0]        rd_sum;
	logic [PW-1:0]      rd_next;
	logic [AW-1:0]      wr_next;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign q_push = accept;

	// saturate the request size
	assign nbits = (item.bit_count > NBITS_W'(MAX_FIELD_BITS)) ?
	               NBITS_W'(MAX_FIELD_BITS) : item.bit_count;

	// position arithmetic with ring wrap
	assign count_plus8 = {1'b0, count_q} + (CW + 1)'(8);
	assign rd_sum      = {1'b0, rd_pos_q} + (PW + 1)'(nbits);
	assign rd_next     = (rd_sum >= (PW + 1)'(TB)) ? PW'(rd_sum - (PW + 1)'(TB)) :
	                     rd_sum[PW-1:0];
	assign wr_next     = (wr_pos_q == AW'(BUFFER_BYTES - 1)) ? '0 : wr_pos_q + 1'b1;

	// classify the item and update the bookkeeping
	always_comb begin
		rd_pos_d     = rd_pos_q;
		wr_pos_d     = wr_pos_q;
		count_d      = count_q;
		q_op.kind    = OP_NONE;
		q_op.status  = ST_OK;
		q_op.data    = item.data_byte;
		q_op.addr    = MAX_ADDR_W'(wr_pos_q);
		q_op.pos     = MAX_POS_W'(rd_pos_q);
		q_op.nbits   = nbits;
		unique case (item.req_type)
			REQ_PUSH: begin
				if (count_plus8 > (CW + 1)'(TB)) begin
					q_op.status = ST_FULL;
				end else begin
					q_op.kind = OP_WRITE;
					wr_pos_d  = wr_next;
					count_d   = count_plus8[CW-1:0];
				end
			end
			REQ_READ: begin
				if (nbits == '0) begin
					q_op.status = ST_OK;
				end else if (CW'(nbits) > count_q) begin
					q_op.status = ST_SHORT;
				end else begin
					q_op.kind = OP_EXTRACT;
					rd_pos_d  = rd_next;
					count_d   = count_q - CW'(nbits);
				end
			end
			REQ_CLEAR: begin
				rd_pos_d = '0;
				wr_pos_d = '0;
				count_d  = '0;
			end
			default: begin
				q_op.status = ST_OK;
			end
		endcase
	end

	// bookkeeping registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pos_q <= '0;
			wr_pos_q <= '0;
			count_q  <= '0;
		end else if (accept) begin
			rd_pos_q <= rd_pos_d;
			wr_pos_q <= wr_pos_d;
			count_q  <= count_d;
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TB) && rd_pos_q <= PW'(TB - 1))
		else $error("buffered bit count or read position out of range");

	a_extract_covered: assert property (@(posedge clk) disable iff (!arst_n)
		accept && q_op.kind == OP_EXTRACT |-> q_op.nbits != '0 && CW'(q_op.nbits) <= count_q)
		else $error("extract issued without enough buffered bits");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.req_type == REQ_CLEAR |=> count_q == '0 && rd_pos_q == '0 &&
		wr_pos_q == '0)
		else $error("clear left state behind");

	a_write_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && q_op.kind == OP_WRITE |=> count_q == $past(count_q) + CW'(8))
		else $error("byte transfer did not add eight bits");

endmodule

### sv/mbfr_back.sv
`timescale 1ns / 1ps

module mbfr_back #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mbfr_pkg::op_t       q_op,
	input  logic                q_empty,
	output logic                q_pop,
	input  logic                o_full,
	output logic                o_push,
	output mbfr_pkg::out_item_t o_item
);

	import mbfr_pkg::*;

	localparam int TB    = BUFFER_BYTES * 8;
	localparam int PW    = $clog2(TB);
	localparam int AW    = $clog2(BUFFER_BYTES);
	localparam int WORDS = BUFFER_BYTES / 4;
	localparam int WW    = $clog2(WORDS);

	// words of four stream bytes, first byte in the top lane
	logic [3:0][7:0]    mem [WORDS];

	logic               adv;
	logic               go_s2;
	logic [WW-1:0]      waddr;
	logic [1:0]         lane;
	logic [WW-1:0]      w0;
	logic [WW-1:0]      w1;
	logic               v_s2;
	op_kind_t           kind_s2;
	logic [1:0]         status_s2;
	logic [4:0]         off_s2;
	logic [NBITS_W-1:0] nbits_s2;
	logic [31:0]        rd0_s2;
	logic [31:0]        rd1_s2;
	logic [63:0]        window;
	logic [31:0]        top;

	// stage handshake
	assign go_s2 = v_s2 && !o_full;
	assign adv   = !q_empty && (!v_s2 || go_s2);
	assign q_pop = adv;

	// store addressing
	assign waddr = q_op.addr[AW-1:2];
	assign lane  = q_op.addr[1:0];
	assign w0    = q_op.pos[PW-1:5];
	assign w1    = (w0 == WW'(WORDS - 1)) ? '0 : w0 + 1'b1;

	// byte store: one byte write, two word reads, registered
	always_ff @(posedge clk) begin
		if (adv && q_op.kind == OP_WRITE) begin
			mem[waddr][~lane] <= q_op.data;
		end
		if (adv) begin
			rd0_s2 <= mem[w0];
			rd1_s2 <= mem[w1];
		end
	end

	// stage two control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= 1'b1;
		end else if (go_s2) begin
			v_s2 <= 1'b0;
		end
	end

	// stage two payload
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2   <= q_op.kind;
			status_s2 <= q_op.status;
			off_s2    <= q_op.pos[4:0];
			nbits_s2  <= q_op.nbits;
		end
	end

	// align the field to the top, then right-align by its length
	assign window = {rd0_s2, rd1_s2};
	assign top    = window[63 - off_s2 -: 32];

	always_comb begin
		o_item.status      = status_s2;
		o_item.field_value = '0;
		if (kind_s2 == OP_EXTRACT) begin
			o_item.field_value = top >> (NBITS_W'(FIELD_W) - nbits_s2);
		end
	end

	assign o_push = go_s2;

endmodule

### sv/msb_first_bit_field_reader_top.sv
`timescale 1ns / 1ps

// msb-first bit field reader
// input channel: item carries req_type, data_byte and bit_count; an item
// transfers on a clock edge with push high and full low
// result channel: result carries field_value and status; the oldest result is
// valid while empty is low and transfers on an edge with pop high
// every item gives exactly one result, in order
// a push appends data_byte to the ring store (status full when no room),
// a read returns the next bit_count bits right-aligned (status short and
// nothing consumed when too few bits are buffered), a clear empties the store
// a result passes through the op queue, the stage-two registers and the result queue
// throughput: one item per cycle while pop keeps the result queue from filling, set by
// the byte store, which serves one byte write and one two-word read per cycle
// a receiver that holds pop low fills the result queue, then the op queue,
// and full rises; nothing is lost and the block resumes when pop returns
// reset clears positions, counts and queues at once; store contents need no
// clearing since only written bytes are ever read
// BUFFER_BYTES must be a multiple of four, 8 to 4096

module msb_first_bit_field_reader_top #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mbfr_pkg::in_item_t  item,
	output logic                full,
	output logic                empty,
	input  logic                pop,
	output mbfr_pkg::out_item_t result
);

	import mbfr_pkg::*;

	localparam int OP_W  = $bits(op_t);
	localparam int OUT_W = $bits(out_item_t);

	logic      q_full;
	logic      q_push;
	op_t       q_op_in;
	op_t       q_op_out;
	logic      q_empty;
	logic      q_pop;
	logic      o_full;
	logic      o_push;
	out_item_t o_item;

	// front: accept and classify
	mbfr_front #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.q_full (q_full),
		.q_push (q_push),
		.q_op   (q_op_in)
	);

	// op queue between front and back
	mbfr_fifo #(
		.WIDTH(OP_W),
		.DEPTH(4)
	) u_op_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_op_in),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_op_out),
		.empty  (q_empty)
	);

	// back: store access and field extraction
	mbfr_back #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_op    (q_op_out),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.o_full  (o_full),
		.o_push  (o_push),
		.o_item  (o_item)
	);

	// result queue
	mbfr_fifo #(
		.WIDTH(OUT_W),
		.DEPTH(2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (o_push),
		.wdata  (o_item),
		.full   (o_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
